// ----- src/sqa_pkg.sv -----
// ----------------------------------------------------------------------------
// sqa_pkg: shared definitions for the sampled quadrature accumulator
// Widths, rule codes, status codes, quantized weight tables and the small
// helper functions for weight selection, phase arithmetic and status.
// ----------------------------------------------------------------------------
package sqa_pkg;

	localparam int unsigned MAX_SAMPLES      = 1048576;
	localparam int unsigned WEIGHT_FRAC_BITS = 24;

	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned STEP_W     = 32;
	localparam int unsigned RESULT_W   = 64;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned TAIL_LEN = 6;
	localparam int unsigned WGT_W    = WEIGHT_FRAC_BITS + 1;
	localparam int unsigned OPA_W    = SAMPLE_W + 1;
	localparam int unsigned OPB_W    = ((WGT_W > STEP_W) ? WGT_W : STEP_W) + 1;
	localparam int unsigned PROD_W   = OPA_W + OPB_W;
	localparam int unsigned SUM_W    = SAMPLE_W + WEIGHT_FRAC_BITS + $clog2(MAX_SAMPLES) + 2;
	localparam int unsigned CHUNK_W  = SAMPLE_W;
	localparam int unsigned NCHUNK   = (SUM_W + CHUNK_W - 1) / CHUNK_W;
	localparam int unsigned SH_W     = NCHUNK * CHUNK_W;
	localparam int unsigned CH_W     = $clog2(NCHUNK);
	localparam int unsigned ACC_W    = SUM_W + STEP_W;

	localparam int unsigned MIN_EXT4A = 8;
	localparam int unsigned MIN_NR3   = 5;
	localparam int unsigned MIN_NR4   = 6;
	localparam int unsigned MIN_TRAP  = 7;
	localparam int unsigned TRAP_PANEL = 6;
	localparam int unsigned N_END0 = 4;
	localparam int unsigned N_END1 = 2;
	localparam int unsigned N_END2 = 3;
	localparam int unsigned NC6_ROW = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'b1;
	localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(65536);

	typedef enum logic [MODE_W-1:0] {
		MODE_EXT4A    = 3'd0,
		MODE_NR3      = 3'd1,
		MODE_NR4      = 3'd2,
		MODE_NC3      = 3'd3,
		MODE_NC4      = 3'd4,
		MODE_NC5      = 3'd5,
		MODE_NC6      = 3'd6,
		MODE_NC6_TRAP = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_SHORT      = 2'd1,
		STATUS_MISALIGNED = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] m4;
		logic [2:0] m5;
		logic [2:0] m6;
	} phase_t;

	typedef struct packed {
		logic                    en;
		logic signed [OPA_W-1:0] a;
		logic signed [OPB_W-1:0] b;
	} sqa_mul_req_t;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (WEIGHT_FRAC_BITS - 1);
	localparam logic [RESULT_W-1:0] RESULT_MAX = {1'b0, {(RESULT_W - 1){1'b1}}};
	localparam logic [RESULT_W-1:0] RESULT_MIN = {1'b1, {(RESULT_W - 1){1'b0}}};

	// Weights are round-half-up of num/den in WEIGHT_FRAC_BITS fraction bits.
	localparam logic [63:0] FRAC_ONE = 64'd1 << WEIGHT_FRAC_BITS;

	localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(FRAC_ONE);
	localparam logic [WGT_W-1:0] W_HALF = WGT_W'((FRAC_ONE + 64'd1) / 64'd2);

	localparam logic [WGT_W-1:0] W_END0 [N_END0] = '{
		WGT_W'((64'd17 * FRAC_ONE + 64'd24) / 64'd48),
		WGT_W'((64'd59 * FRAC_ONE + 64'd24) / 64'd48),
		WGT_W'((64'd43 * FRAC_ONE + 64'd24) / 64'd48),
		WGT_W'((64'd49 * FRAC_ONE + 64'd24) / 64'd48)
	};

	localparam logic [WGT_W-1:0] W_END1 [N_END1] = '{
		WGT_W'((64'd5 * FRAC_ONE + 64'd6) / 64'd12),
		WGT_W'((64'd13 * FRAC_ONE + 64'd6) / 64'd12)
	};

	// The fourth entry only pads the table to a power of two.
	localparam logic [WGT_W-1:0] W_END2 [4] = '{
		WGT_W'((64'd9 * FRAC_ONE + 64'd12) / 64'd24),
		WGT_W'((64'd28 * FRAC_ONE + 64'd12) / 64'd24),
		WGT_W'((64'd23 * FRAC_ONE + 64'd12) / 64'd24),
		WGT_W'(FRAC_ONE)
	};

	// Row t holds the rule with t+3 intervals; entry 0 is the end weight.
	localparam logic [WGT_W-1:0] W_NC [4][6] = '{
		'{WGT_W'((64'd3 * FRAC_ONE + 64'd4) / 64'd8),
		  WGT_W'((64'd9 * FRAC_ONE + 64'd4) / 64'd8),
		  WGT_W'((64'd9 * FRAC_ONE + 64'd4) / 64'd8),
		  '0, '0, '0},
		'{WGT_W'((64'd28 * FRAC_ONE + 64'd45) / 64'd90),
		  WGT_W'((64'd128 * FRAC_ONE + 64'd45) / 64'd90),
		  WGT_W'((64'd48 * FRAC_ONE + 64'd45) / 64'd90),
		  WGT_W'((64'd128 * FRAC_ONE + 64'd45) / 64'd90),
		  '0, '0},
		'{WGT_W'((64'd95 * FRAC_ONE + 64'd144) / 64'd288),
		  WGT_W'((64'd375 * FRAC_ONE + 64'd144) / 64'd288),
		  WGT_W'((64'd250 * FRAC_ONE + 64'd144) / 64'd288),
		  WGT_W'((64'd250 * FRAC_ONE + 64'd144) / 64'd288),
		  WGT_W'((64'd375 * FRAC_ONE + 64'd144) / 64'd288),
		  '0},
		'{WGT_W'((64'd246 * FRAC_ONE + 64'd420) / 64'd840),
		  WGT_W'((64'd1296 * FRAC_ONE + 64'd420) / 64'd840),
		  WGT_W'((64'd162 * FRAC_ONE + 64'd420) / 64'd840),
		  WGT_W'((64'd1632 * FRAC_ONE + 64'd420) / 64'd840),
		  WGT_W'((64'd162 * FRAC_ONE + 64'd420) / 64'd840),
		  WGT_W'((64'd1296 * FRAC_ONE + 64'd420) / 64'd840)}
	};

	// Weight of a node shared by two adjacent panels.
	localparam logic [WGT_W-1:0] W_NC_IN [4] = '{
		WGT_W'((64'd6 * FRAC_ONE + 64'd4) / 64'd8),
		WGT_W'((64'd56 * FRAC_ONE + 64'd45) / 64'd90),
		WGT_W'((64'd190 * FRAC_ONE + 64'd144) / 64'd288),
		WGT_W'((64'd492 * FRAC_ONE + 64'd420) / 64'd840)
	};

	// Node where the last full six-interval panel meets the trapezoid tail.
	localparam logic [WGT_W-1:0] W_NC6_JOIN = WGT_W'((64'd666 * FRAC_ONE + 64'd420) / 64'd840);

	function automatic logic [2:0] period_of(input mode_t mode);
		logic [2:0] k;
		unique case (mode)
			MODE_EXT4A, MODE_NR3, MODE_NR4: k = 3'd1;
			MODE_NC3:                       k = 3'd3;
			MODE_NC4:                       k = 3'd4;
			MODE_NC5:                       k = 3'd5;
			MODE_NC6, MODE_NC6_TRAP:        k = 3'd6;
		endcase
		return k;
	endfunction

	// Sample count modulo k for k of 3 to 6, taken from the running phase counters.
	function automatic logic [2:0] count_phase(input logic [2:0] k, input phase_t ph);
		logic [2:0] base;
		unique case (k)
			3'd3:    base = (ph.m6 >= 3'd3) ? ph.m6 - 3'd3 : ph.m6;
			3'd4:    base = {1'b0, ph.m4};
			3'd5:    base = ph.m5;
			default: base = ph.m6;
		endcase
		return base;
	endfunction

	// (base - sub) mod k for base < k and sub <= 2k.
	function automatic logic [2:0] residue(input logic [2:0] k, input logic [2:0] base,
			input logic [2:0] sub);
		logic [4:0] t;
		t = 5'(base) + 5'(k) + 5'(k) - 5'(sub);
		for (int s = 0; s < 2; s++) begin
			if (t >= 5'(k)) t = t - 5'(k);
		end
		return t[2:0];
	endfunction

	// When known is low the vector length is still open and rdist is ignored.
	function automatic logic [WGT_W-1:0] weight_of(input mode_t mode,
			input logic [CNT_W-1:0] idx, input logic known, input logic [2:0] rdist,
			input logic [2:0] jph, input logic [2:0] qrem, input logic b_nz);
		logic [2:0]       k;
		logic [1:0]       t;
		logic [WGT_W-1:0] w;
		k = period_of(mode);
		t = 2'(k - 3'd3);
		unique case (mode)
			MODE_EXT4A: begin
				priority if (idx < CNT_W'(N_END0)) w = W_END0[idx[1:0]];
				else if (known && rdist < 3'(N_END0)) w = W_END0[rdist[1:0]];
				else w = W_ONE;
			end
			MODE_NR3: begin
				priority if (idx < CNT_W'(N_END1)) w = W_END1[idx[0]];
				else if (known && rdist < 3'(N_END1)) w = W_END1[rdist[0]];
				else w = W_ONE;
			end
			MODE_NR4: begin
				priority if (idx < CNT_W'(N_END2)) w = W_END2[idx[1:0]];
				else if (known && rdist < 3'(N_END2)) w = W_END2[rdist[1:0]];
				else w = W_ONE;
			end
			default: begin
				priority if (mode == MODE_NC6_TRAP && known && rdist < qrem)
					w = (rdist == 3'd0) ? W_HALF : W_ONE;
				else if (mode == MODE_NC6_TRAP && known && rdist == qrem && b_nz)
					w = (qrem != 3'd0) ? W_NC6_JOIN : W_NC[NC6_ROW][0];
				else if (idx == '0 || (known && rdist == 3'd0))
					w = W_NC[t][0];
				else if (jph == 3'd0)
					w = W_NC_IN[t];
				else
					w = W_NC[t][jph];
			end
		endcase
		return w;
	endfunction

	function automatic status_t status_of(input mode_t mode, input logic [CNT_W-1:0] n,
			input logic [2:0] q1);
		status_t s;
		s = STATUS_OK;
		unique case (mode)
			MODE_EXT4A:    if (n < CNT_W'(MIN_EXT4A)) s = STATUS_SHORT;
			MODE_NR3:      if (n < CNT_W'(MIN_NR3)) s = STATUS_SHORT;
			MODE_NR4:      if (n < CNT_W'(MIN_NR4)) s = STATUS_SHORT;
			MODE_NC6_TRAP: if (n < CNT_W'(MIN_TRAP)) s = STATUS_SHORT;
			default: begin
				priority if (n < CNT_W'(period_of(mode)) + CNT_W'(1)) s = STATUS_SHORT;
				else if (q1 != 3'd0) s = STATUS_MISALIGNED;
			end
		endcase
		return s;
	endfunction

endpackage

// ----- src/sqa_ifs.sv -----
// ----------------------------------------------------------------------------
// sqa_ifs: stream channels of the sampled quadrature accumulator
// One channel carries samples in, the other carries integration results out.
// ----------------------------------------------------------------------------
interface sqa_sample_if import sqa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       is_last;

	modport source (output valid, output sample_value, output is_last, input ready);
	modport sink (input valid, input sample_value, input is_last, output ready);
endinterface

interface sqa_result_if import sqa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [RESULT_W-1:0] integral_value;
	logic [STATUS_W-1:0]        status;

	modport source (output valid, output integral_value, output status, input ready);
	modport sink (input valid, input integral_value, input status, output ready);
endinterface

// ----- src/sqa_mul.sv -----
// ----------------------------------------------------------------------------
// sqa_mul: shared signed multiplier
// Registers the product of two signed operands when enabled; used for the
// sample terms and for the chunked multiply by the step size.
// ----------------------------------------------------------------------------
module sqa_mul import sqa_pkg::*; (
	input  logic                     clk,
	input  sqa_mul_req_t             req,
	output logic signed [PROD_W-1:0] product
);

	logic signed [PROD_W-1:0] product_q;

	always_ff @(posedge clk) begin
		if (req.en) product_q <= req.a * req.b;
	end

	assign product = product_q;

endmodule

// ----- src/sampled_quadrature_accumulator.sv -----
// ----------------------------------------------------------------------------
// sampled_quadrature_accumulator: streaming Newton-Cotes integrator
// Weights each sample by its rule position, holds the last six samples for
// their end weights, and on the last sample scales the sum by the step size.
//
//   channel     direction  beat contents
//   sample_ch   in         sample_value (Q16.16), is_last
//   result_ch   out        integral_value (Q32.32, saturated), status
//   cfg_*       in         write of rule_mode or step_size, one per cycle
//
// While fewer than six samples are held a sample is only stored; after that
// each one also passes load, multiply and accumulate through the one shared
// multiplier before the next is taken. The last sample adds a tail pass
// (set, multiply, accumulate per held sample), the chunked step multiply and
// rounding, then the result waits for its beat. Samples are not taken while
// a result is pending. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sampled_quadrature_accumulator import sqa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sqa_sample_if.sink            sample_ch,
	sqa_result_if.source          result_ch
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_MUL   = 14'h0002,
		ST_ACC   = 14'h0004,
		ST_FIN   = 14'h0008,
		ST_TSET  = 14'h0010,
		ST_TMUL  = 14'h0020,
		ST_TACC  = 14'h0040,
		ST_HSET  = 14'h0080,
		ST_HLOAD = 14'h0100,
		ST_HMUL  = 14'h0200,
		ST_HACC  = 14'h0400,
		ST_RND   = 14'h0800,
		ST_SAT   = 14'h1000,
		ST_OUT   = 14'h2000
	} state_t;

	state_t                    state_q;
	mode_t                     mode_q;
	logic [STEP_W-1:0]         step_q;
	logic [SAMPLE_W-1:0]       tail_q [TAIL_LEN];
	logic [CNT_W-1:0]          count_q;
	phase_t                    phase_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      last_q;
	logic [2:0]                d_q;
	logic [CH_W-1:0]           ch_q;
	logic [SH_W-1:0]           sh_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [OPA_W-1:0]   op_a_q;
	logic signed [OPB_W-1:0]   op_b_q;
	logic [RESULT_W-1:0]       res_q;
	status_t                   status_q;

	sqa_mul_req_t              mul_req;
	logic signed [PROD_W-1:0]  product;

	logic                      accept;
	logic                      stored;
	logic                      clear_vec;
	logic [2:0]                k;
	logic [2:0]                base;
	logic [2:0]                q1;
	logic [2:0]                q_trap;
	logic [2:0]                j_stream;
	logic [2:0]                j_tail;
	logic [CNT_W-1:0]          idx_stream;
	logic [CNT_W-1:0]          idx_tail;
	logic [WGT_W-1:0]          w_stream;
	logic [WGT_W-1:0]          w_tail;
	logic [2:0]                tail_len;
	status_t                   status_now;
	logic signed [ACC_W-1:0]   shifted;
	logic [ACC_W-RESULT_W:0]   upper;
	logic [RESULT_W-1:0]       sat_value;

	assign accept = sample_ch.valid && sample_ch.ready;
	assign stored = count_q < CNT_W'(MAX_SAMPLES);

	assign k          = period_of(mode_q);
	assign base       = count_phase(k, phase_q);
	assign q1         = residue(k, base, 3'd1);
	assign q_trap     = residue(3'(TRAP_PANEL), count_phase(3'(TRAP_PANEL), phase_q), 3'd1);
	assign j_stream   = residue(k, base, 3'(TAIL_LEN));
	assign j_tail     = residue(k, base, d_q + 3'd1);
	assign idx_stream = count_q - CNT_W'(TAIL_LEN);
	assign idx_tail   = count_q - CNT_W'(1) - CNT_W'(d_q);
	assign w_stream   = weight_of(mode_q, idx_stream, 1'b0, 3'd0, j_stream, 3'd0, 1'b0);
	assign w_tail     = weight_of(mode_q, idx_tail, 1'b1, d_q, j_tail, q_trap,
		count_q > CNT_W'(TRAP_PANEL));
	assign tail_len   = (count_q < CNT_W'(TAIL_LEN)) ? count_q[2:0] : 3'(TAIL_LEN);
	assign status_now = status_of(mode_q, count_q, q1);
	assign clear_vec  = (state_q == ST_FIN && status_now != STATUS_OK) || state_q == ST_SAT;

	assign shifted   = acc_q >>> WEIGHT_FRAC_BITS;
	assign upper     = shifted[ACC_W-1:RESULT_W-1];
	assign sat_value = ((&upper) || !(|upper)) ? shifted[RESULT_W-1:0] :
		(shifted[ACC_W-1] ? RESULT_MIN : RESULT_MAX);

	assign mul_req.en = state_q == ST_MUL || state_q == ST_TMUL || state_q == ST_HMUL;
	assign mul_req.a  = op_a_q;
	assign mul_req.b  = op_b_q;

	sqa_mul u_mul (
		.clk     (clk),
		.req     (mul_req),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXT4A;
			step_q <= STEP_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_RULE_MODE: mode_q <= mode_t'(cfg_wdata[MODE_W-1:0]);
				REG_STEP_SIZE: step_q <= cfg_wdata[STEP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
			d_q     <= '0;
			ch_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= sample_ch.is_last;
						if (stored && count_q >= CNT_W'(TAIL_LEN)) state_q <= ST_MUL;
						else if (sample_ch.is_last) state_q <= ST_FIN;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_FIN: begin
					d_q     <= '0;
					state_q <= (status_now != STATUS_OK) ? ST_OUT : ST_TSET;
				end
				ST_TSET: state_q <= ST_TMUL;
				ST_TMUL: state_q <= ST_TACC;
				ST_TACC: begin
					d_q     <= d_q + 3'd1;
					state_q <= (d_q + 3'd1 == tail_len) ? ST_HSET : ST_TSET;
				end
				ST_HSET: begin
					ch_q    <= '0;
					state_q <= ST_HLOAD;
				end
				ST_HLOAD: state_q <= ST_HMUL;
				ST_HMUL:  state_q <= ST_HACC;
				ST_HACC: begin
					ch_q    <= ch_q + CH_W'(1);
					state_q <= (ch_q == CH_W'(NCHUNK - 1)) ? ST_RND : ST_HLOAD;
				end
				ST_RND: state_q <= ST_SAT;
				ST_SAT: state_q <= ST_OUT;
				ST_OUT: if (result_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Delay line, sample count and phase counters. During the tail pass the line
	// shifts the other way so the newest sample not yet weighted is at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAIL_LEN; t++) tail_q[t] <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else if (clear_vec) begin
			for (int t = 0; t < TAIL_LEN; t++) tail_q[t] <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else if (accept && stored) begin
			for (int t = 0; t < TAIL_LEN - 1; t++) tail_q[t] <= tail_q[t + 1];
			tail_q[TAIL_LEN - 1] <= sample_ch.sample_value;
			count_q    <= count_q + CNT_W'(1);
			phase_q.m4 <= phase_q.m4 + 2'd1;
			phase_q.m5 <= (phase_q.m5 == 3'd4) ? 3'd0 : phase_q.m5 + 3'd1;
			phase_q.m6 <= (phase_q.m6 == 3'd5) ? 3'd0 : phase_q.m6 + 3'd1;
		end else if (state_q == ST_TSET) begin
			for (int t = 1; t < TAIL_LEN; t++) tail_q[t] <= tail_q[t - 1];
			tail_q[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear_vec) begin
			sum_q <= '0;
		end else if (state_q == ST_ACC || state_q == ST_TACC) begin
			sum_q <= sum_q + SUM_W'(product);
		end
	end

	// The step multiply runs over the sum in chunks, most significant first,
	// so each partial product folds in with a fixed shift.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_a_q <= OPA_W'($signed(tail_q[0]));
				op_b_q <= OPB_W'(w_stream);
			end
			ST_TSET: begin
				op_a_q <= OPA_W'($signed(tail_q[TAIL_LEN - 1]));
				op_b_q <= OPB_W'(w_tail);
			end
			ST_HSET: begin
				sh_q  <= SH_W'(sum_q);
				acc_q <= '0;
			end
			ST_HLOAD: begin
				if (ch_q == '0) op_a_q <= OPA_W'($signed(sh_q[SH_W-1 -: CHUNK_W]));
				else op_a_q <= OPA_W'(sh_q[SH_W-1 -: CHUNK_W]);
				op_b_q <= OPB_W'(step_q);
				sh_q   <= sh_q << CHUNK_W;
			end
			ST_HACC: acc_q <= (acc_q <<< CHUNK_W) + ACC_W'(product);
			ST_RND:  acc_q <= acc_q + ROUND_HALF;
			ST_SAT: begin
				res_q    <= sat_value;
				status_q <= STATUS_OK;
			end
			ST_FIN: begin
				if (status_now != STATUS_OK) begin
					res_q    <= '0;
					status_q <= status_now;
				end
			end
			default: ;
		endcase
	end

	assign sample_ch.ready          = state_q == ST_IDLE;
	assign result_ch.valid          = state_q == ST_OUT;
	assign result_ch.integral_value = res_q;
	assign result_ch.status         = status_q;

endmodule

// ----- src/sqa_checker.sv -----
// ----------------------------------------------------------------------------
// sqa_checker: port-level checks for the sampled quadrature accumulator
// Watches the sample and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sqa_checker import sqa_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [RESULT_W-1:0] out_value,
	input logic [STATUS_W-1:0]        out_status
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
		else $error("result beat changed while stalled");

	// No sample is taken while a result waits.
	a_no_take_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("sample channel ready while a result is pending");

	// A failed vector reports a zero integral.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != STATUS_OK |-> out_value == '0)
		else $error("nonzero integral with error status");

	// A result beat is not repeated once it has been taken.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result repeated after its beat");

endmodule

bind sampled_quadrature_accumulator sqa_checker u_sqa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_value  (result_ch.integral_value),
	.out_status (result_ch.status)
);
